// ----- hdl/anbt_pkg.sv -----
// Shared constants, types and the microcode table of the aging neighbor table.
`timescale 1ns / 1ps

package anbt_pkg;

  // Table geometry
  localparam int TABLE_SIZE = 20;
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
  localparam int ADDR_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int SLOT_W     = 5;
  localparam int CMP_W      = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  // Field widths
  localparam int ID_W   = 16;
  localparam int HD_W   = 13;
  localparam int TIME_W = 32;
  localparam int OP_W   = 2;

  // Configuration register indexes and reset values
  localparam int          CFG_IDX_W     = 1;
  localparam int          CFG_DATA_W    = 32;
  localparam logic        REG_MAX_AGE   = 1'b0;
  localparam logic        REG_OWN_ID    = 1'b1;
  localparam logic [31:0] MAX_AGE_RESET = 32'd600;
  localparam logic [15:0] OWN_ID_RESET  = 16'd0;

  // Operation codes
  localparam logic [OP_W-1:0] OP_OBSERVE = 2'd0;
  localparam logic [OP_W-1:0] OP_PURGE   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ    = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

  // Jump conditions
  localparam int COND_W = 4;
  localparam logic [COND_W-1:0] C_NEVER       = 4'd0;
  localparam logic [COND_W-1:0] C_ALWAYS      = 4'd1;
  localparam logic [COND_W-1:0] C_OWN         = 4'd2;
  localparam logic [COND_W-1:0] C_IDX_GE_CNT  = 4'd3;
  localparam logic [COND_W-1:0] C_NOT_HIT     = 4'd4;
  localparam logic [COND_W-1:0] C_FULL        = 4'd5;
  localparam logic [COND_W-1:0] C_IDX_ZERO    = 4'd6;
  localparam logic [COND_W-1:0] C_NOT_EXPIRED = 4'd7;
  localparam logic [COND_W-1:0] C_SLOT_GE_CNT = 4'd8;

  // Read address select
  localparam logic [1:0] RD_IDX    = 2'd0;
  localparam logic [1:0] RD_IDX_M1 = 2'd1;
  localparam logic [1:0] RD_TOP    = 2'd2;
  localparam logic [1:0] RD_SLOT   = 2'd3;

  // Index register operation
  localparam logic [2:0] IX_HOLD     = 3'd0;
  localparam logic [2:0] IX_CLEAR    = 3'd1;
  localparam logic [2:0] IX_LOAD_CNT = 3'd2;
  localparam logic [2:0] IX_INC      = 3'd3;
  localparam logic [2:0] IX_DEC      = 3'd4;

  // Memory write operation
  localparam logic [1:0] WR_NONE = 2'd0;
  localparam logic [1:0] WR_HIT  = 2'd1;  // refresh entry idx-1
  localparam logic [1:0] WR_NEW  = 2'd2;  // append at count
  localparam logic [1:0] WR_COPY = 2'd3;  // move read data to entry idx

  // Count operation
  localparam logic [1:0] CN_HOLD = 2'd0;
  localparam logic [1:0] CN_INC  = 2'd1;
  localparam logic [1:0] CN_DEC  = 2'd2;

  // Microprogram step addresses
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] S_IDLE      = 4'd0;
  localparam logic [PC_W-1:0] S_O_START   = 4'd1;
  localparam logic [PC_W-1:0] S_O_SCAN    = 4'd2;
  localparam logic [PC_W-1:0] S_O_CMP     = 4'd3;
  localparam logic [PC_W-1:0] S_O_HIT     = 4'd4;
  localparam logic [PC_W-1:0] S_O_MISS    = 4'd5;
  localparam logic [PC_W-1:0] S_O_APPEND  = 4'd6;
  localparam logic [PC_W-1:0] S_P_START   = 4'd7;
  localparam logic [PC_W-1:0] S_P_LOOP    = 4'd8;
  localparam logic [PC_W-1:0] S_P_CHECK   = 4'd9;
  localparam logic [PC_W-1:0] S_P_TOP     = 4'd10;
  localparam logic [PC_W-1:0] S_P_MOVE    = 4'd11;
  localparam logic [PC_W-1:0] S_R_START   = 4'd12;
  localparam logic [PC_W-1:0] S_R_CAPTURE = 4'd13;
  localparam logic [PC_W-1:0] S_DONE      = 4'd14;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [HD_W-1:0]   heading;
    logic [TIME_W-1:0] last_seen;
    logic [TIME_W-1:0] first_seen;
  } entry_t;

  typedef struct packed {
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
    logic [1:0]        rd_sel;
    logic [2:0]        idx_op;
    logic [1:0]        wr_op;
    logic [1:0]        cnt_op;
    logic              set_acc;
    logic              set_added;
    logic              rem_inc;
    logic              cap_read;
    logic              done;
  } ctrl_t;

  typedef struct packed {
    logic own;
    logic idx_ge_cnt;
    logic hit;
    logic full;
    logic idx_zero;
    logic expired;
    logic slot_ge_cnt;
  } stat_t;

  typedef struct packed {
    logic              acc;
    logic              added;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  removed;
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [HD_W-1:0]   heading;
    logic [TIME_W-1:0] age;
  } res_t;

  function automatic ctrl_t mk(input logic [COND_W-1:0] cond, input logic [PC_W-1:0] target,
                               input logic [1:0] rd_sel, input logic [2:0] idx_op,
                               input logic [1:0] wr_op, input logic [1:0] cnt_op,
                               input logic set_acc, input logic set_added,
                               input logic rem_inc, input logic cap_read, input logic done);
    ctrl_t c;
    c.cond      = cond;
    c.target    = target;
    c.rd_sel    = rd_sel;
    c.idx_op    = idx_op;
    c.wr_op     = wr_op;
    c.cnt_op    = cnt_op;
    c.set_acc   = set_acc;
    c.set_added = set_added;
    c.rem_inc   = rem_inc;
    c.cap_read  = cap_read;
    c.done      = done;
    return c;
  endfunction

  // Microcode ROM
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    unique case (pc)
      S_IDLE:      c = mk(C_NEVER, S_IDLE, RD_IDX, IX_HOLD, WR_NONE, CN_HOLD,
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      // observe
      S_O_START:   c = mk(C_OWN, S_DONE, RD_IDX, IX_CLEAR, WR_NONE, CN_HOLD,
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      S_O_SCAN:    c = mk(C_IDX_GE_CNT, S_O_MISS, RD_IDX, IX_INC, WR_NONE, CN_HOLD,
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      // re-read entry idx-1 so the hit step still holds it
      S_O_CMP:     c = mk(C_NOT_HIT, S_O_SCAN, RD_IDX_M1, IX_HOLD, WR_NONE, CN_HOLD,
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      S_O_HIT:     c = mk(C_ALWAYS, S_DONE, RD_IDX, IX_HOLD, WR_HIT, CN_HOLD,
                          1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      S_O_MISS:    c = mk(C_FULL, S_DONE, RD_IDX, IX_HOLD, WR_NONE, CN_HOLD,
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      S_O_APPEND:  c = mk(C_ALWAYS, S_DONE, RD_IDX, IX_HOLD, WR_NEW, CN_INC,
                          1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
      // purge
      S_P_START:   c = mk(C_NEVER, S_IDLE, RD_IDX, IX_LOAD_CNT, WR_NONE, CN_HOLD,
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      S_P_LOOP:    c = mk(C_IDX_ZERO, S_DONE, RD_IDX_M1, IX_DEC, WR_NONE, CN_HOLD,
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      S_P_CHECK:   c = mk(C_NOT_EXPIRED, S_P_LOOP, RD_IDX, IX_HOLD, WR_NONE, CN_HOLD,
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      S_P_TOP:     c = mk(C_NEVER, S_IDLE, RD_TOP, IX_HOLD, WR_NONE, CN_HOLD,
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      S_P_MOVE:    c = mk(C_ALWAYS, S_P_LOOP, RD_IDX, IX_HOLD, WR_COPY, CN_DEC,
                          1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
      // read
      S_R_START:   c = mk(C_SLOT_GE_CNT, S_DONE, RD_SLOT, IX_HOLD, WR_NONE, CN_HOLD,
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      S_R_CAPTURE: c = mk(C_ALWAYS, S_DONE, RD_IDX, IX_HOLD, WR_NONE, CN_HOLD,
                          1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
      S_DONE:      c = mk(C_NEVER, S_IDLE, RD_IDX, IX_HOLD, WR_NONE, CN_HOLD,
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
      default:     c = mk(C_ALWAYS, S_IDLE, RD_IDX, IX_HOLD, WR_NONE, CN_HOLD,
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    endcase
    return c;
  endfunction

  // Entry point of each operation
  function automatic logic [PC_W-1:0] dispatch(input logic [OP_W-1:0] op);
    logic [PC_W-1:0] pc;
    unique case (op)
      OP_OBSERVE: pc = S_O_START;
      OP_PURGE:   pc = S_P_START;
      OP_READ:    pc = S_R_START;
      OP_NOP:     pc = S_DONE;
      default:    pc = S_DONE;
    endcase
    return pc;
  endfunction

endpackage

// ----- hdl/anbt_seq.sv -----
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
`timescale 1ns / 1ps

module anbt_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_accept,
  input  logic [anbt_pkg::OP_W-1:0]  in_operation,
  input  anbt_pkg::stat_t            stat,
  input  logic                       out_busy,
  output anbt_pkg::ctrl_t            ctrl,
  output logic                       idle,
  output logic                       done_fire
);

  logic [anbt_pkg::PC_W-1:0] pc_r;
  logic [anbt_pkg::PC_W-1:0] pc_nxt;
  logic                      take;

  assign ctrl      = anbt_pkg::ucode(pc_r);
  assign idle      = (pc_r == anbt_pkg::S_IDLE);
  assign done_fire = ctrl.done && !out_busy;

  always_comb begin
    case (ctrl.cond)
      anbt_pkg::C_NEVER:       take = 1'b0;
      anbt_pkg::C_ALWAYS:      take = 1'b1;
      anbt_pkg::C_OWN:         take = stat.own;
      anbt_pkg::C_IDX_GE_CNT:  take = stat.idx_ge_cnt;
      anbt_pkg::C_NOT_HIT:     take = !stat.hit;
      anbt_pkg::C_FULL:        take = stat.full;
      anbt_pkg::C_IDX_ZERO:    take = stat.idx_zero;
      anbt_pkg::C_NOT_EXPIRED: take = !stat.expired;
      anbt_pkg::C_SLOT_GE_CNT: take = stat.slot_ge_cnt;
      default:                 take = 1'b0;
    endcase
  end

  always_comb begin
    if (idle) begin
      pc_nxt = in_accept ? anbt_pkg::dispatch(in_operation) : anbt_pkg::S_IDLE;
    end else if (ctrl.done) begin
      pc_nxt = out_busy ? pc_r : anbt_pkg::S_IDLE;
    end else if (take) begin
      pc_nxt = ctrl.target;
    end else begin
      pc_nxt = pc_r + anbt_pkg::PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= anbt_pkg::S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

`ifndef SYNTH
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_fire |=> pc_r == anbt_pkg::S_IDLE)
    else $error("sequencer did not return to idle after finishing an item");

  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.done && out_busy) |=> pc_r == anbt_pkg::S_DONE)
    else $error("sequencer left the finish step while the result slot was full");
`endif

endmodule

// ----- hdl/anbt_dp.sv -----
// Datapath: entry memory, count, index, config registers and result registers.
`timescale 1ns / 1ps

module anbt_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_accept,
  input  logic [anbt_pkg::ID_W-1:0]        in_neighbor_id,
  input  logic signed [anbt_pkg::HD_W-1:0] in_heading_mrad,
  input  logic [anbt_pkg::TIME_W-1:0]      in_now_ms,
  input  logic [anbt_pkg::SLOT_W-1:0]      in_slot_index,
  input  logic                             cfg_we,
  input  logic [anbt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [anbt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  anbt_pkg::ctrl_t                  ctrl,
  output anbt_pkg::stat_t                  stat,
  output anbt_pkg::res_t                   res
);

  localparam int CW = anbt_pkg::CNT_W;
  localparam int AW = anbt_pkg::ADDR_W;

  // Configuration
  logic [anbt_pkg::TIME_W-1:0] max_age_r;
  logic [anbt_pkg::ID_W-1:0]   own_id_r;

  // Control state
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;

  // Item fields held for the whole walk
  logic [anbt_pkg::ID_W-1:0]   lat_id_r;
  logic [anbt_pkg::HD_W-1:0]   lat_hd_r;
  logic [anbt_pkg::TIME_W-1:0] lat_now_r;
  logic [anbt_pkg::SLOT_W-1:0] lat_slot_r;

  // Per-item results
  logic                        acc_r;
  logic                        added_r;
  logic [CW-1:0]               removed_r;
  logic                        valid_r;
  logic [anbt_pkg::ID_W-1:0]   eid_r;
  logic [anbt_pkg::HD_W-1:0]   ehd_r;
  logic [anbt_pkg::TIME_W-1:0] eage_r;

  // Entry memory, one write and one registered read per cycle
  anbt_pkg::entry_t entry_mem_r [anbt_pkg::TABLE_SIZE];
  anbt_pkg::entry_t rdata_r;
  anbt_pkg::entry_t wr_data;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic             wr_en;

  logic [CW-1:0]                  idx_m1;
  logic [CW-1:0]                  top;
  logic [anbt_pkg::CMP_W-1:0]     slot_x;
  logic [anbt_pkg::TIME_W-1:0]    since_last;

  assign idx_m1     = idx_r - CW'(1);
  assign top        = count_r - CW'(1);
  assign slot_x     = anbt_pkg::CMP_W'(lat_slot_r);
  assign since_last = lat_now_r - rdata_r.last_seen;

  always_comb begin
    case (ctrl.rd_sel)
      anbt_pkg::RD_IDX:    rd_addr = idx_r[AW-1:0];
      anbt_pkg::RD_IDX_M1: rd_addr = idx_m1[AW-1:0];
      anbt_pkg::RD_TOP:    rd_addr = top[AW-1:0];
      anbt_pkg::RD_SLOT:   rd_addr = slot_x[AW-1:0];
      default:             rd_addr = idx_r[AW-1:0];
    endcase
  end

  always_comb begin
    wr_en   = (ctrl.wr_op != anbt_pkg::WR_NONE);
    wr_addr = idx_r[AW-1:0];
    wr_data = rdata_r;
    case (ctrl.wr_op)
      anbt_pkg::WR_HIT: begin
        wr_addr           = idx_m1[AW-1:0];
        wr_data.heading   = lat_hd_r;
        wr_data.last_seen = lat_now_r;
      end
      anbt_pkg::WR_NEW: begin
        wr_addr            = count_r[AW-1:0];
        wr_data.id         = lat_id_r;
        wr_data.heading    = lat_hd_r;
        wr_data.last_seen  = lat_now_r;
        wr_data.first_seen = lat_now_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem_r[wr_addr] <= wr_data;
    end
    rdata_r <= entry_mem_r[rd_addr];
  end

  assign stat.own         = (lat_id_r == own_id_r);
  assign stat.idx_ge_cnt  = (idx_r >= count_r);
  assign stat.hit         = (rdata_r.id == lat_id_r);
  assign stat.full        = (count_r >= CW'(anbt_pkg::TABLE_SIZE));
  assign stat.idx_zero    = (idx_r == '0);
  assign stat.expired     = (since_last > max_age_r);
  assign stat.slot_ge_cnt = (slot_x >= anbt_pkg::CMP_W'(count_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_age_r <= anbt_pkg::MAX_AGE_RESET;
      own_id_r  <= anbt_pkg::OWN_ID_RESET;
      count_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          anbt_pkg::REG_MAX_AGE: max_age_r <= cfg_data;
          anbt_pkg::REG_OWN_ID:  own_id_r  <= cfg_data[anbt_pkg::ID_W-1:0];
          default: ;
        endcase
      end
      case (ctrl.cnt_op)
        anbt_pkg::CN_INC: count_r <= count_r + CW'(1);
        anbt_pkg::CN_DEC: count_r <= top;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.idx_op)
      anbt_pkg::IX_CLEAR:    idx_r <= '0;
      anbt_pkg::IX_LOAD_CNT: idx_r <= count_r;
      anbt_pkg::IX_INC:      idx_r <= idx_r + CW'(1);
      anbt_pkg::IX_DEC:      idx_r <= idx_m1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      lat_id_r   <= in_neighbor_id;
      lat_hd_r   <= in_heading_mrad;
      lat_now_r  <= in_now_ms;
      lat_slot_r <= in_slot_index;
      acc_r      <= 1'b0;
      added_r    <= 1'b0;
      removed_r  <= '0;
      valid_r    <= 1'b0;
      eid_r      <= '0;
      ehd_r      <= '0;
      eage_r     <= '0;
    end else begin
      if (ctrl.set_acc) acc_r <= 1'b1;
      if (ctrl.set_added) added_r <= 1'b1;
      if (ctrl.rem_inc) removed_r <= removed_r + CW'(1);
      if (ctrl.cap_read) begin
        valid_r <= 1'b1;
        eid_r   <= rdata_r.id;
        ehd_r   <= rdata_r.heading;
        eage_r  <= lat_now_r - rdata_r.first_seen;
      end
    end
  end

  assign res.acc     = acc_r;
  assign res.added   = added_r;
  assign res.cnt     = count_r;
  assign res.removed = removed_r;
  assign res.valid   = valid_r;
  assign res.id      = eid_r;
  assign res.heading = ehd_r;
  assign res.age     = eage_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(anbt_pkg::TABLE_SIZE))
    else $error("entry count above table size");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.wr_op == anbt_pkg::WR_NEW |-> !stat.full && ctrl.cnt_op == anbt_pkg::CN_INC)
    else $error("append into a full table or without a count step");

  a_remove_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.cnt_op == anbt_pkg::CN_DEC |-> count_r != '0 && idx_r < count_r)
    else $error("removal from an empty table or beyond the top entry");
`endif

endmodule

// ----- hdl/aging_neighbor_table.sv -----
// Aging neighbor table top level: sequencer, datapath and result register.
// Observe and purge walk the stored entries in the entry memory, two microcode
// steps per entry; a purge takes two more steps for each entry that it removes.
// One item at a time; the next item is taken the cycle after the result is
// registered.
// Reset: count cleared, max_age_ms to 600, own_id to 0; entry memory not cleared.
`timescale 1ns / 1ps

module aging_neighbor_table (
  input  logic                             clk,
  input  logic                             rst_n,
  // input items
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [anbt_pkg::OP_W-1:0]        in_operation,
  input  logic [anbt_pkg::ID_W-1:0]        in_neighbor_id,
  input  logic signed [anbt_pkg::HD_W-1:0] in_heading_mrad,
  input  logic [anbt_pkg::TIME_W-1:0]      in_now_ms,
  input  logic [anbt_pkg::SLOT_W-1:0]      in_slot_index,
  // result items
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_accepted,
  output logic                             out_newly_added,
  output logic [4:0]                       out_neighbor_count,
  output logic [4:0]                       out_removed_count,
  output logic                             out_entry_valid,
  output logic [anbt_pkg::ID_W-1:0]        out_entry_id,
  output logic signed [anbt_pkg::HD_W-1:0] out_entry_heading_mrad,
  output logic [anbt_pkg::TIME_W-1:0]      out_entry_age_ms,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [anbt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [anbt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  anbt_pkg::ctrl_t ctrl;
  anbt_pkg::stat_t stat;
  anbt_pkg::res_t  res;

  logic in_accept;
  logic idle;
  logic done_fire;
  logic out_busy;
  logic out_valid_r;

  // New items enter only while the sequencer sits idle; a finished result
  // waits in the output register, so the next item can start meanwhile.
  assign in_ready  = idle;
  assign in_accept = in_valid && in_ready;
  assign out_busy  = out_valid_r && !out_ready;

  anbt_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_accept    (in_accept),
    .in_operation (in_operation),
    .stat         (stat),
    .out_busy     (out_busy),
    .ctrl         (ctrl),
    .idle         (idle),
    .done_fire    (done_fire)
  );

  anbt_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_accept       (in_accept),
    .in_neighbor_id  (in_neighbor_id),
    .in_heading_mrad (in_heading_mrad),
    .in_now_ms       (in_now_ms),
    .in_slot_index   (in_slot_index),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .ctrl            (ctrl),
    .stat            (stat),
    .res             (res)
  );

  // Output register: loaded when the finish step fires, held until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_accepted           <= res.acc;
      out_newly_added        <= res.added;
      out_neighbor_count     <= 5'(res.cnt);
      out_removed_count      <= 5'(res.removed);
      out_entry_valid        <= res.valid;
      out_entry_id           <= res.id;
      out_entry_heading_mrad <= res.heading;
      out_entry_age_ms       <= res.age;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    done_fire |-> !out_valid_r || out_ready)
    else $error("result register overwritten before the item was taken");
`endif

endmodule
